[design/afs_pkg.sv]
// ----------------------------------------------------------------------------
// afs_pkg
// Shared codes and the command/status bundles between the argument field
// splitter controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package afs_pkg;

    // result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_FINAL = 2'd2;

    // final status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_LONG   = 2'd2;
    localparam logic [1:0] ST_MANY   = 2'd3;

    // blank characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic       take;        // input request accepted this cycle
        logic       chars_zero;  // restart the field character count
        logic       chars_inc;   // count one more character
        logic       push_blank;  // hold back one blank
        logic       blank_tab;   // held-back blank is a tab
        logic       pc_zero;     // drop held-back blanks
        logic       err_set;     // latch an error code
        logic [1:0] err_val;
        logic [7:0] char_val;    // decoded character of the request
        logic       emit;        // load the output register
        logic       emit_blank;  // emitted character is a held-back blank
        logic [1:0] emit_kind;
        logic [1:0] emit_status;
        logic       emit_last;
        logic       fld_inc;     // field complete
        logic       flush_step;  // advance through held-back blanks
        logic       clear;       // string done, back to reset state
    } afs_cmd_t;

    typedef struct packed {
        logic       room_ok;     // field can take one more character
        logic       net_zero;    // no characters besides held-back blanks
        logic       cf_full;     // all fields used
        logic       pend_empty;  // no held-back blanks
        logic       flush_last;  // last held-back blank is next
        logic       out_free;    // output register can load
        logic [1:0] err;         // latched error
    } afs_stat_t;

endpackage

`default_nettype wire

[design/at_argument_field_splitter_core.sv]
// A byte is taken only when the splitter is idle; the sequencer state then
// loads its first result into the output register; one result a cycle follows
// while m_tready does not stall. A byte with no result leaves the input free;
// one with k results holds it until all k are loaded (more while m_tready is
// low); k reaches FIELD_BYTES when held-back blanks are flushed ahead of a character.
// Reset (rst_n low, asynchronous): parser before the first field, counts clear.
// ----------------------------------------------------------------------------
// at_argument_field_splitter_core
// Splits an AT-command argument byte stream into comma-separated fields.
// ----------------------------------------------------------------------------
`default_nettype none

module at_argument_field_splitter_core #(
    parameter int FIELD_BYTES = 32,
    parameter int MAX_FIELDS  = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // end_of_args
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] data_byte, [10:8] field_number,
                                        // [12:11] status, [16:13] field_total
    output logic [1:0]       m_tuser,   // [1:0] item_kind
    output logic             m_tlast    // last_of_run
);
    import afs_pkg::*;

    afs_cmd_t  cmd;
    afs_stat_t st;

    afs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .st       (st),
        .cmd      (cmd)
    );

    afs_dpath #(
        .FIELD_BYTES (FIELD_BYTES),
        .MAX_FIELDS  (MAX_FIELDS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`default_nettype wire
endmodule

[design/afs_ctrl.sv]
// ----------------------------------------------------------------------------
// afs_ctrl
// Parse phase tracking, per-byte decode and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module afs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    input  wire afs_pkg::afs_stat_t st,
    output afs_pkg::afs_cmd_t      cmd
);
    import afs_pkg::*;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    typedef enum logic [2:0] {
        PH_LEAD, PH_QUOTED, PH_ESCAPE, PH_AFTERQ, PH_PLAIN, PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE, S_FLUSH, S_CHAR, S_END, S_FINAL
    } seq_t;

    phase_t     ph_reg, ph_next, ph_dec;
    seq_t       state_reg, state_next, first_state, after_state;
    logic       chr_reg, chr_next;
    logic       end_reg, end_next;
    logic       fin_reg, fin_next;
    logic [1:0] st_reg, st_next;

    // decode results
    logic       d_flush, d_chr, d_end, d_fin;
    logic [1:0] d_st;
    logic [7:0] d_val;
    logic       d_chars_zero, d_chars_inc, d_push, d_pc_zero, d_err_set;
    logic [1:0] d_err_val;
    logic       lead, room_e, net0_e, blank, ctl, plain_sel, q_sel, f;
    logic [7:0] q_val;
    logic [1:0] fst;
    logic       take;

    assign take     = s_tvalid && (state_reg == S_IDLE);
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        d_flush      = 1'b0;
        d_chr        = 1'b0;
        d_end        = 1'b0;
        d_fin        = 1'b0;
        d_st         = ST_OK;
        d_val        = s_tdata;
        d_chars_zero = 1'b0;
        d_chars_inc  = 1'b0;
        d_push       = 1'b0;
        d_pc_zero    = 1'b0;
        d_err_set    = 1'b0;
        d_err_val    = ST_OK;
        ph_dec       = ph_reg;
        plain_sel    = 1'b0;
        q_sel        = 1'b0;
        q_val        = s_tdata;
        f            = 1'b0;
        fst          = ST_OK;
        lead         = (ph_reg == PH_LEAD);
        room_e       = lead || st.room_ok;
        net0_e       = lead || st.net_zero;
        blank        = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
        ctl          = (s_tdata < CH_SPACE);

        unique case (ph_reg)
            PH_LEAD:
            begin
                if (st.cf_full)
                begin
                    f   = 1'b1;
                    fst = ST_MANY;
                end
                else if (blank)
                begin
                    f   = s_tlast;
                    fst = ST_SYNTAX;
                end
                else if (s_tdata == CH_QUOTE)
                begin
                    d_chars_zero = 1'b1;
                    ph_dec       = PH_QUOTED;
                    f            = s_tlast;
                    fst          = ST_SYNTAX;
                end
                else
                begin
                    plain_sel = 1'b1;
                end
            end
            PH_PLAIN:
                plain_sel = 1'b1;
            PH_QUOTED:
            begin
                if (s_tdata == CH_QUOTE)
                begin
                    d_end  = 1'b1;
                    ph_dec = PH_AFTERQ;
                    d_fin  = s_tlast;
                end
                else if (s_tdata == CH_BSLASH)
                begin
                    ph_dec = PH_ESCAPE;
                    f      = s_tlast;
                    fst    = ST_SYNTAX;
                end
                else
                begin
                    q_sel = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                if ((s_tdata == CH_QUOTE) || (s_tdata == CH_BSLASH))
                begin
                    q_sel = 1'b1;
                end
                else if (s_tdata == CH_LOW_R)
                begin
                    q_sel = 1'b1;
                    q_val = CH_CR;
                end
                else if (s_tdata == CH_LOW_N)
                begin
                    q_sel = 1'b1;
                    q_val = CH_LF;
                end
                else if (s_tdata == CH_LOW_T)
                begin
                    q_sel = 1'b1;
                    q_val = CH_TAB;
                end
                else
                begin
                    f   = 1'b1;
                    fst = ST_SYNTAX;
                end
            end
            PH_AFTERQ:
            begin
                if (blank)
                begin
                    d_fin = s_tlast;
                end
                else if (s_tdata == CH_COMMA)
                begin
                    ph_dec = PH_LEAD;
                    f      = s_tlast;
                    fst    = ST_SYNTAX;
                end
                else
                begin
                    f   = 1'b1;
                    fst = ST_SYNTAX;
                end
            end
            default:
            begin
                // swallow until the end of the string
                d_fin = s_tlast;
                d_st  = st.err;
            end
        endcase

        if (plain_sel)
        begin
            if (s_tdata == CH_COMMA)
            begin
                if (net0_e)
                begin
                    f   = 1'b1;
                    fst = ST_SYNTAX;
                end
                else
                begin
                    d_pc_zero = 1'b1;
                    d_end     = 1'b1;
                    ph_dec    = PH_LEAD;
                    f         = s_tlast;
                    fst       = ST_SYNTAX;
                end
            end
            else if ((s_tdata == CH_QUOTE) || (s_tdata == CH_BSLASH) ||
                     (ctl && (s_tdata != CH_TAB)))
            begin
                f   = 1'b1;
                fst = ST_SYNTAX;
            end
            else if (!room_e)
            begin
                f   = 1'b1;
                fst = ST_LONG;
            end
            else
            begin
                d_chars_zero = lead;
                d_chars_inc  = 1'b1;
                ph_dec       = PH_PLAIN;
                if (blank)
                begin
                    d_push = 1'b1;
                end
                else
                begin
                    d_flush = 1'b1;
                    d_chr   = 1'b1;
                end
                if (s_tlast)
                begin
                    // trailing blanks are trimmed; a blank-only field is an error
                    if (blank && net0_e)
                    begin
                        f   = 1'b1;
                        fst = ST_SYNTAX;
                    end
                    else
                    begin
                        d_end = 1'b1;
                        d_fin = 1'b1;
                    end
                end
            end
        end

        if (q_sel)
        begin
            if ((q_val < CH_SPACE) && (q_val != CH_CR) && (q_val != CH_LF) &&
                (q_val != CH_TAB))
            begin
                f   = 1'b1;
                fst = ST_SYNTAX;
            end
            else if (!st.room_ok)
            begin
                f   = 1'b1;
                fst = ST_LONG;
            end
            else
            begin
                d_chars_inc = 1'b1;
                d_chr       = 1'b1;
                d_val       = q_val;
                ph_dec      = PH_QUOTED;
                f           = s_tlast;
                fst         = ST_SYNTAX;
            end
        end

        if (f)
        begin
            if (s_tlast)
            begin
                d_fin = 1'b1;
                d_st  = fst;
            end
            else
            begin
                d_err_set = 1'b1;
                d_err_val = fst;
                ph_dec    = PH_ERROR;
            end
        end

        if (d_fin)
        begin
            ph_dec = PH_LEAD;
        end
    end

    always_comb
    begin
        priority if (d_flush && !st.pend_empty)
            first_state = S_FLUSH;
        else if (d_chr)
            first_state = S_CHAR;
        else if (d_end)
            first_state = S_END;
        else if (d_fin)
            first_state = S_FINAL;
        else
            first_state = S_IDLE;
    end

    always_comb
    begin
        after_state = S_IDLE;
        unique case (state_reg)
            S_FLUSH:
                after_state = st.flush_last ? S_CHAR : S_FLUSH;
            S_CHAR:
                after_state = end_reg ? S_END : (fin_reg ? S_FINAL : S_IDLE);
            S_END:
                after_state = fin_reg ? S_FINAL : S_IDLE;
            default:
                after_state = S_IDLE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        chr_next   = chr_reg;
        end_next   = end_reg;
        fin_next   = fin_reg;
        st_next    = st_reg;
        if (take)
        begin
            state_next = first_state;
            ph_next    = ph_dec;
            chr_next   = d_chr;
            end_next   = d_end;
            fin_next   = d_fin;
            st_next    = d_st;
        end
        else if ((state_reg != S_IDLE) && st.out_free)
        begin
            state_next = after_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_LEAD;
            chr_reg   <= 1'b0;
            end_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            chr_reg   <= chr_next;
            end_reg   <= end_next;
            fin_reg   <= fin_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.take        = take;
        cmd.chars_zero  = take && d_chars_zero;
        cmd.chars_inc   = take && d_chars_inc;
        cmd.push_blank  = take && d_push;
        cmd.blank_tab   = (s_tdata == CH_TAB);
        cmd.pc_zero     = take && d_pc_zero;
        cmd.err_set     = take && d_err_set;
        cmd.err_val     = d_err_val;
        cmd.char_val    = d_val;
        cmd.emit        = (state_reg != S_IDLE) && st.out_free;
        cmd.emit_blank  = (state_reg == S_FLUSH);
        cmd.emit_status = st_reg;
        cmd.emit_kind   = KIND_CHAR;
        cmd.emit_last   = 1'b0;
        unique case (state_reg)
            S_CHAR:
                cmd.emit_last = !end_reg && !fin_reg;
            S_END:
            begin
                cmd.emit_kind = KIND_END;
                cmd.emit_last = !fin_reg;
            end
            S_FINAL:
            begin
                cmd.emit_kind = KIND_FINAL;
                cmd.emit_last = 1'b1;
            end
            default:
                cmd.emit_last = 1'b0;
        endcase
        cmd.fld_inc    = cmd.emit && (state_reg == S_END);
        cmd.flush_step = cmd.emit && (state_reg == S_FLUSH);
        cmd.clear      = cmd.emit && (state_reg == S_FINAL);
    end

    a_flush_has_blanks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> !st.pend_empty)
        else $error("flush sequence with no held-back blanks");

    a_error_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (ph_reg == PH_ERROR) |-> (st.err != ST_OK))
        else $error("error phase without a latched error code");

    a_flush_then_char: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> chr_reg)
        else $error("held-back blanks flushed without a following character");

`default_nettype wire
endmodule

[design/afs_dpath.sv]
// ----------------------------------------------------------------------------
// afs_dpath
// Field counters, held-back blank store, latched error and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module afs_dpath #(
    parameter int FIELD_BYTES = 32,
    parameter int MAX_FIELDS  = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire afs_pkg::afs_cmd_t  cmd,
    output afs_pkg::afs_stat_t      st,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);
    import afs_pkg::*;

    localparam int CHW = $clog2(FIELD_BYTES);
    localparam int CFW = $clog2(MAX_FIELDS + 1);
    localparam int TD  = FIELD_BYTES - 1;
    localparam int IW  = (TD > 1) ? $clog2(TD) : 1;

    logic [CFW-1:0] cf_reg, cf_next;
    logic [CHW-1:0] chars_reg, chars_next;
    logic [CHW-1:0] pc_reg, pc_next;
    logic [CHW-1:0] idx_reg, idx_next;
    logic [1:0]     err_reg, err_next;
    logic [7:0]     char_reg;
    logic           tab_reg [TD];
    logic           mv_reg, mv_next;
    logic [23:0]    td_reg, td_next;
    logic [1:0]     tu_reg;
    logic           tl_reg;
    logic [31:0]    cf_wide;
    logic [3:0]     total;
    logic [7:0]     data_sel;

    assign cf_wide = 32'(cf_reg);
    assign total   = (cf_wide > 32'd15) ? 4'd15 : cf_wide[3:0];

    always_comb
    begin
        st.room_ok    = ((CHW + 1)'(chars_reg) + (CHW + 1)'(1)) < (CHW + 1)'(FIELD_BYTES);
        st.net_zero   = (chars_reg == pc_reg);
        st.cf_full    = (cf_reg >= CFW'(MAX_FIELDS));
        st.pend_empty = (pc_reg == '0);
        st.flush_last = ((idx_reg + CHW'(1)) == pc_reg);
        st.out_free   = !mv_reg || m_tready;
        st.err        = err_reg;
    end

    always_comb
    begin
        cf_next    = cf_reg;
        chars_next = chars_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        err_next   = err_reg;
        if (cmd.take)
        begin
            chars_next = (cmd.chars_zero ? '0 : chars_reg) + CHW'(cmd.chars_inc);
            if (cmd.push_blank)
                pc_next = pc_reg + CHW'(1);
            else if (cmd.pc_zero)
                pc_next = '0;
            if (cmd.err_set)
                err_next = cmd.err_val;
        end
        if (cmd.flush_step)
        begin
            // drop the held-back blanks once the last one has gone out
            if (st.flush_last)
            begin
                idx_next = '0;
                pc_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + CHW'(1);
            end
        end
        if (cmd.fld_inc)
            cf_next = cf_reg + CFW'(1);
        if (cmd.clear)
        begin
            cf_next    = '0;
            chars_next = '0;
            pc_next    = '0;
            idx_next   = '0;
            err_next   = ST_OK;
        end
    end

    always_comb
    begin
        data_sel = cmd.emit_blank ? (tab_reg[idx_reg[IW-1:0]] ? CH_TAB : CH_SPACE)
                                  : char_reg;
        td_next  = '0;
        unique case (cmd.emit_kind)
            KIND_CHAR:
                td_next = {7'd0, 4'd0, 2'd0, cf_wide[2:0], data_sel};
            KIND_END:
                td_next = {7'd0, 4'd0, 2'd0, cf_wide[2:0], 8'd0};
            KIND_FINAL:
                td_next = {7'd0, total, cmd.emit_status, 3'd0, 8'd0};
            default:
                td_next = '0;
        endcase
        mv_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : mv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cf_reg    <= '0;
            chars_reg <= '0;
            pc_reg    <= '0;
            idx_reg   <= '0;
            err_reg   <= ST_OK;
            mv_reg    <= 1'b0;
        end
        else
        begin
            cf_reg    <= cf_next;
            chars_reg <= chars_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            err_reg   <= err_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            char_reg <= cmd.char_val;
        if (cmd.take && cmd.push_blank)
            tab_reg[pc_reg[IW-1:0]] <= cmd.blank_tab;
        if (cmd.emit)
        begin
            td_reg <= td_next;
            tu_reg <= cmd.emit_kind;
            tl_reg <= cmd.emit_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = td_reg;
    assign m_tuser  = tu_reg;
    assign m_tlast  = tl_reg;

    a_pend_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= chars_reg)
        else $error("held-back blanks exceed field characters");

    a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cf_wide <= 32'(MAX_FIELDS))
        else $error("field count beyond limit");

    a_final_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && (tu_reg == KIND_FINAL)) |-> tl_reg)
        else $error("final status not marked last");

`default_nettype wire
endmodule

[tb/sv/tb_at_argument_field_splitter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_at_argument_field_splitter_core
// Self-checking bench for the argument field splitter. A behavioral model of
// the parser predicts the field characters, end marks and final status of
// every accepted byte. A checker compares each result with the oldest
// prediction. Directed strings cover plain and quoted fields, the length
// and count limits and the syntax errors. Random strings follow, mostly
// well formed with some noise and damage. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb_at_argument_field_splitter_core;

    import afs_pkg::*;

    localparam int FIELD_BYTES  = 32;
    localparam int MAX_FIELDS   = 8;
    localparam int RANDOM_BYTES = 20;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = FIELD_BYTES + 8;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_QUOTED,
        PH_ESCAPE,
        PH_AFTERQ,
        PH_PLAIN,
        PH_ERROR
    } split_phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] fno;
        logic [1:0] status;
        logic [3:0] total;
        logic       last;
    } split_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    at_argument_field_splitter_core #(
        .FIELD_BYTES (FIELD_BYTES),
        .MAX_FIELDS  (MAX_FIELDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    split_phase_t  sp_phase = PH_LEAD;
    int unsigned   sp_fields = 0;
    int unsigned   sp_chars = 0;
    logic          sp_blank_tab [FIELD_BYTES];
    int unsigned   sp_blanks = 0;
    logic [1:0]    sp_error = ST_OK;
    split_result_t byte_results_q [$];
    split_result_t field_results_q [$];

    function automatic void add_result(logic [1:0] kind, logic [7:0] data,
                                       int unsigned fno, logic [1:0] status,
                                       int unsigned total);
        split_result_t r;
        r.kind   = kind;
        r.data   = data;
        r.fno    = fno[2:0];
        r.status = status;
        r.total  = (total > 15) ? 4'd15 : total[3:0];
        r.last   = 1'b0;
        byte_results_q.push_back(r);
    endfunction

    function automatic void close_string(logic [1:0] status);
        add_result(KIND_FINAL, 8'h00, 0, status, sp_fields);
        sp_phase  = PH_LEAD;
        sp_fields = 0;
        sp_chars  = 0;
        sp_blanks = 0;
        sp_error  = ST_OK;
    endfunction

    function automatic void raise_error(logic [1:0] status, logic last);
        sp_error = status;
        sp_phase = PH_ERROR;
        if (last)
            close_string(status);
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic take_room();
        if (sp_chars + 1 >= FIELD_BYTES)
            return 1'b0;
        sp_chars++;
        return 1'b1;
    endfunction

    function automatic void close_field();
        add_result(KIND_END, 8'h00, sp_fields, ST_OK, 0);
        sp_fields++;
    endfunction

    function automatic void plain_char(logic [7:0] c, logic last);
        if (c == CH_COMMA)
        begin
            if (sp_chars - sp_blanks == 0)
            begin
                raise_error(ST_SYNTAX, last);
                return;
            end
            sp_blanks = 0;
            close_field();
            sp_phase = PH_LEAD;
            if (last)
                raise_error(ST_SYNTAX, 1'b1);
            return;
        end
        if (c == CH_QUOTE || c == CH_BSLASH || (c < 8'h20 && c != CH_TAB))
        begin
            raise_error(ST_SYNTAX, last);
            return;
        end
        if (!take_room())
        begin
            raise_error(ST_LONG, last);
            return;
        end
        if (is_blank(c))
        begin
            // hold back until a non-blank shows the blanks are interior
            if (sp_blanks < FIELD_BYTES)
                sp_blank_tab[sp_blanks] = (c == CH_TAB);
            sp_blanks++;
        end
        else
        begin
            for (int unsigned i = 0; i < sp_blanks && i < FIELD_BYTES; i++)
                add_result(KIND_CHAR, sp_blank_tab[i] ? CH_TAB : CH_SPACE,
                           sp_fields, ST_OK, 0);
            sp_blanks = 0;
            add_result(KIND_CHAR, c, sp_fields, ST_OK, 0);
        end
        if (last)
        begin
            if (sp_chars - sp_blanks == 0)
            begin
                raise_error(ST_SYNTAX, 1'b1);
                return;
            end
            sp_blanks = 0;
            close_field();
            close_string(ST_OK);
        end
    endfunction

    function automatic void quoted_char(logic [7:0] c, logic last);
        if (c < 8'h20 && c != CH_CR && c != CH_LF && c != CH_TAB)
        begin
            raise_error(ST_SYNTAX, last);
            return;
        end
        if (!take_room())
        begin
            raise_error(ST_LONG, last);
            return;
        end
        add_result(KIND_CHAR, c, sp_fields, ST_OK, 0);
        sp_phase = PH_QUOTED;
        if (last)
            raise_error(ST_SYNTAX, 1'b1);
    endfunction

    function automatic void split_byte(logic [7:0] c, logic last);
        split_result_t r;
        case (sp_phase)
            PH_LEAD:
            begin
                if (sp_fields >= MAX_FIELDS)
                    raise_error(ST_MANY, last);
                else if (is_blank(c))
                begin
                    if (last)
                        raise_error(ST_SYNTAX, 1'b1);
                end
                else if (c == CH_QUOTE)
                begin
                    sp_chars = 0;
                    sp_phase = PH_QUOTED;
                    if (last)
                        raise_error(ST_SYNTAX, 1'b1);
                end
                else
                begin
                    sp_chars  = 0;
                    sp_blanks = 0;
                    sp_phase  = PH_PLAIN;
                    plain_char(c, last);
                end
            end
            PH_QUOTED:
            begin
                if (c == CH_QUOTE)
                begin
                    close_field();
                    sp_phase = PH_AFTERQ;
                    if (last)
                        close_string(ST_OK);
                end
                else if (c == CH_BSLASH)
                begin
                    sp_phase = PH_ESCAPE;
                    if (last)
                        raise_error(ST_SYNTAX, 1'b1);
                end
                else
                    quoted_char(c, last);
            end
            PH_ESCAPE:
            begin
                if (c == CH_QUOTE || c == CH_BSLASH)
                    quoted_char(c, last);
                else if (c == "r")
                    quoted_char(CH_CR, last);
                else if (c == "n")
                    quoted_char(CH_LF, last);
                else if (c == "t")
                    quoted_char(CH_TAB, last);
                else
                    raise_error(ST_SYNTAX, last);
            end
            PH_AFTERQ:
            begin
                if (is_blank(c))
                begin
                    if (last)
                        close_string(ST_OK);
                end
                else if (c == CH_COMMA)
                begin
                    sp_phase = PH_LEAD;
                    if (last)
                        raise_error(ST_SYNTAX, 1'b1);
                end
                else
                    raise_error(ST_SYNTAX, last);
            end
            PH_PLAIN:
                plain_char(c, last);
            default:
            begin
                // swallow until the final byte reports the latched error
                if (last)
                    close_string(sp_error);
            end
        endcase
        for (int i = 0; i < byte_results_q.size(); i++)
        begin
            r = byte_results_q[i];
            r.last = (i == byte_results_q.size() - 1);
            field_results_q.push_back(r);
        end
        byte_results_q.delete();
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    int unsigned error_count = 0;

    always @(posedge clk)
    begin
        split_result_t got;
        split_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind   = m_tuser;
            got.data   = m_tdata[7:0];
            got.fno    = m_tdata[10:8];
            got.status = m_tdata[12:11];
            got.total  = m_tdata[16:13];
            got.last   = m_tlast;
            if (field_results_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: kind=%0d data=%02h fno=%0d st=%0d tot=%0d",
                             got.kind, got.data, got.fno, got.status, got.total,
                             " last=%0d", got.last);
            end
            else
            begin
                want = field_results_q.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.fno !== want.fno || got.status !== want.status ||
                    got.total !== want.total || got.last !== want.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("mismatch: expected kind=%0d data=%02h fno=%0d st=%0d",
                                 want.kind, want.data, want.fno, want.status,
                                 " tot=%0d last=%0d", want.total, want.last);
                        $display("          got      kind=%0d data=%02h fno=%0d st=%0d",
                                 got.kind, got.data, got.fno, got.status,
                                 " tot=%0d last=%0d", got.total, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern plus an optional long hold-off
    // ------------------------------------------------------------------
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_mode_left = 0;
    int unsigned rx_tick = 0;

    always @(posedge clk)
    begin
        rx_tick++;
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(8, 64);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_tick % 5) < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;
    logic [7:0]  arg_q [$];

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        split_byte(b, last);
        bytes_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    function automatic void put_byte(logic [7:0] b);
        arg_q.push_back(b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            arg_q.push_back(s[i]);
    endfunction

    task automatic send_args();
        for (int i = 0; i < arg_q.size(); i++)
            send_byte(arg_q[i], i == arg_q.size() - 1);
        arg_q.delete();
    endtask

    task automatic send_text(string s);
        put_text(s);
        send_args();
    endtask

    // Pause the sender until every predicted result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (field_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_plain_fields();
        // interior blanks kept, trailing blanks trimmed, high bytes ordinary
        put_text("ab,  c d \t,");
        put_byte(8'h80);
        put_byte(8'hFF);
        put_byte(8'h7F);
        send_args();
        send_text(" \tx");
    endtask

    task automatic test_quoted_fields();
        put_text("\"q\\\"\\\\\\r\\n\\t\" ,\"\",\"a");
        put_byte(CH_TAB);
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_byte(8'hC3);
        put_text(",b\"\t ");
        send_args();
        send_text("\"z\"");
    endtask

    task automatic test_field_length();
        // longest legal field, flushing the most held-back blanks ahead of
        // its last character
        put_byte("a");
        for (int i = 0; i < FIELD_BYTES - 3; i++)
            put_byte((i % 3 == 0) ? CH_TAB : CH_SPACE);
        put_byte("b");
        send_args();
        // trailing blanks count toward the limit
        for (int i = 0; i < FIELD_BYTES - 2; i++)
            put_byte("a");
        put_text("  ");
        send_args();
        put_byte(CH_QUOTE);
        for (int i = 0; i < FIELD_BYTES; i++)
            put_byte("q");
        put_byte(CH_QUOTE);
        send_args();
    endtask

    task automatic test_field_count();
        send_text("1,2,3,4,5,6,7,8");
        send_text("1,2,3,4,5,6,7,8,9");
    endtask

    task automatic test_syntax_errors();
        send_text(" \t");
        send_text(",");
        send_text(",x");
        send_text("a,,b");
        send_text("a,");
        send_text("a, ");
        send_text("\"ab");
        send_text("\"a\\");
        send_text("\"\\x\"");
        put_byte(CH_QUOTE);
        put_byte(8'h00);
        put_byte(CH_QUOTE);
        send_args();
        send_text("\"a\"b,c");
        send_text("\"a\",");
        send_text("a\"b");
        put_byte("a");
        put_byte(8'h1F);
        put_byte("b");
        send_args();
        send_text("a\\b");
    endtask

    task automatic test_backpressure();
        // hold the output off long enough for the input to stall
        hold_requests++;
        send_text("ab,c  d,\"e\\tf\"");
        drain_results();
    endtask

    function automatic logic [7:0] ordinary_char();
        logic [7:0] c;
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(8'h80, 8'hFF));
        do
            c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == CH_QUOTE || c == CH_COMMA || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] random_blank();
        return ($urandom_range(0, 1) != 0) ? CH_TAB : CH_SPACE;
    endfunction

    function automatic void build_random_args();
        int unsigned nfields;
        int unsigned len;
        int unsigned pick;
        int unsigned cut;
        pick = $urandom_range(0, 9);
        nfields = (pick < 7) ? $urandom_range(1, 3) :
                  (pick < 9) ? $urandom_range(4, MAX_FIELDS) : MAX_FIELDS + 1;
        for (int unsigned f = 0; f < nfields; f++)
        begin
            if (f != 0)
                put_byte(CH_COMMA);
            repeat ($urandom_range(0, 2)) put_byte(random_blank());
            pick = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0)
                len = $urandom_range(FIELD_BYTES - 4, FIELD_BYTES + 1);
            else
                len = $urandom_range(1, 5);
            if (pick < 4)
            begin
                put_byte(ordinary_char());
                for (int unsigned i = 1; i < len; i++)
                    put_byte(($urandom_range(0, 5) == 0) ? random_blank() : ordinary_char());
                repeat ($urandom_range(0, 3)) put_byte(random_blank());
            end
            else if (pick < 8)
            begin
                put_byte(CH_QUOTE);
                if ($urandom_range(0, 3) == 0)
                    len = 0;
                for (int unsigned i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 7))
                        0:
                        begin
                            put_byte(CH_BSLASH);
                            case ($urandom_range(0, 4))
                                0:       put_byte(CH_QUOTE);
                                1:       put_byte(CH_BSLASH);
                                2:       put_byte("r");
                                3:       put_byte("n");
                                default: put_byte("t");
                            endcase
                        end
                        1:       put_byte(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
                        2:       put_byte(($urandom_range(0, 1) != 0) ? CH_COMMA
                                                                      : random_blank());
                        default: put_byte(ordinary_char());
                    endcase
                end
                put_byte(CH_QUOTE);
                repeat ($urandom_range(0, 2)) put_byte(random_blank());
            end
            else
                repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
        end
        // damage a few strings: a stray byte or a cut-off tail
        pick = $urandom_range(0, 9);
        if (pick == 0 && arg_q.size() > 1)
            arg_q[$urandom_range(0, arg_q.size() - 1)] = 8'($urandom);
        else if (pick == 1 && arg_q.size() > 1)
        begin
            cut = $urandom_range(1, arg_q.size() - 1);
            while (arg_q.size() > cut)
                void'(arg_q.pop_back());
        end
    endfunction

    task automatic test_random_strings();
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            build_random_args();
            send_args();
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_fields();
        test_quoted_fields();
        test_field_length();
        test_field_count();
        test_syntax_errors();
        test_backpressure();
        test_random_strings();
        drain_results();
        if (error_count == 0)
            $display("[at_argument_field_splitter_core] OK");
        else
            $display("[at_argument_field_splitter_core] ERROR");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("[at_argument_field_splitter_core] ERROR");
        $finish;
    end

endmodule
